[rtl/salc_pkg.sv]
// shared constants for the set-associative lru cache tag model
`default_nettype none
package salc_pkg;
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 64;
  localparam int WAY_W  = 4;
  localparam int CFG_W  = 4;
  localparam logic [CFG_W-1:0] SIB_RESET = 4'd10;
endpackage
`default_nettype wire

[rtl/salc_front.sv]
// front end: set index register, address split and request queue
`default_nettype none
module salc_front #(
  parameter int LINE_BYTES = 64,
  parameter int MAX_SETS   = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [salc_pkg::ADDR_W-1:0] in_address,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [salc_pkg::CFG_W-1:0]  cfg_set_index_bits,
  input  wire logic                        clearing,
  output logic                             q_valid,
  input  wire logic                        q_ready,
  output logic [$clog2(MAX_SETS+1)-1 > 0 ? $clog2(MAX_SETS+1)-2 : 0 : 0] q_set,
  output logic [salc_pkg::ADDR_W-$clog2(LINE_BYTES)-1:0] q_tag
);
  import salc_pkg::*;

  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int TAG_W    = ADDR_W - OFF_W;
  localparam int MAX_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W    = (MAX_BITS > 0) ? MAX_BITS : 1;

  logic [CFG_W-1:0] sib_r;
  logic [CFG_W-1:0] bits;
  logic [TAG_W-1:0] block, mask, set_full, tag_c;

  logic [SET_W-1:0] qset_r [2];
  logic [TAG_W-1:0] qtag_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sib_r <= SIB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sib_r <= cfg_set_index_bits;
    end
  end

  // set index width saturates at the configured store size
  always_comb begin
    bits     = (sib_r > CFG_W'(MAX_BITS)) ? CFG_W'(MAX_BITS) : sib_r;
    block    = in_address[ADDR_W-1:OFF_W];
    mask     = ~({TAG_W{1'b1}} << bits);
    set_full = block & mask;
    tag_c    = block >> bits;
  end

  assign in_stall = clearing || (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_set    = qset_r[rp_r];
  assign q_tag    = qtag_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      qset_r[wp_r] <= set_full[SET_W-1:0];
      qtag_r[wp_r] <= tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !push)
    else $error("item taken while clearing");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an item");
`endif
endmodule
`default_nettype wire

[rtl/salc_back.sv]
// back end: tag store, lookup and lru victim scan, counters, result register
`default_nettype none
module salc_back #(
  parameter int WAYS       = 16,
  parameter int LINE_BYTES = 64,
  parameter int MAX_SETS   = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  output logic                             clearing,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire logic [$clog2(MAX_SETS+1)-1 > 0 ? $clog2(MAX_SETS+1)-2 : 0 : 0] q_set,
  input  wire logic [salc_pkg::ADDR_W-$clog2(LINE_BYTES)-1:0] q_tag,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic [salc_pkg::WAY_W-1:0]       out_way_used,
  output logic [salc_pkg::CNT_W-1:0]       out_hit_total,
  output logic [salc_pkg::CNT_W-1:0]       out_miss_total
);
  import salc_pkg::*;

  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int TAG_W    = ADDR_W - OFF_W;
  localparam int MAX_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W    = (MAX_BITS > 0) ? MAX_BITS : 1;
  localparam int DEPTH    = 1 << MAX_BITS;
  localparam int WIDX_W   = $clog2(WAYS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_SCAN, ST_WRITE, ST_OUT
  } state_t;

  state_t state_r;

  logic [TAG_W-1:0] tag_mem   [DEPTH][WAYS];
  logic [CNT_W-1:0] stamp_mem [DEPTH][WAYS];
  logic [WAYS-1:0]  valid_mem [DEPTH];

  logic [TAG_W-1:0] row_tag_r   [WAYS];
  logic [CNT_W-1:0] row_stamp_r [WAYS];
  logic [WAYS-1:0]  row_valid_r;

  logic [SET_W-1:0]  set_r, clr_r;
  logic [TAG_W-1:0]  tag_r;
  logic [WIDX_W-1:0] way_r, scan_r;
  logic [CNT_W-1:0]  best_r;
  logic              hit_r;
  logic [CNT_W-1:0]  clock_r, hit_cnt_r, miss_cnt_r;

  logic              rd_en, wr_en;
  logic [WAYS-1:0]   hit_vec;
  logic              any_hit, any_free;
  logic [WIDX_W-1:0] hit_way, free_way;

  assign clearing = (state_r == ST_CLEAR);
  assign q_ready  = (state_r == ST_IDLE);
  assign rd_en    = q_valid && q_ready;
  assign wr_en    = (state_r == ST_WRITE);

  // row read, single-way write, whole-row clear of valid bits
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_tag_r   <= tag_mem[q_set];
      row_stamp_r <= stamp_mem[q_set];
      row_valid_r <= valid_mem[q_set];
    end
    if (clearing) begin
      valid_mem[clr_r] <= '0;
    end else if (wr_en) begin
      valid_mem[set_r][way_r] <= 1'b1;
      stamp_mem[set_r][way_r] <= clock_r;
      if (!hit_r) tag_mem[set_r][way_r] <= tag_r;
    end
  end

  always_comb begin
    hit_vec  = '0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row_valid_r[w] && (row_tag_r[w] == tag_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w])        hit_way  = WIDX_W'(w);
      if (!row_valid_r[w])   free_way = WIDX_W'(w);
    end
    any_hit  = |hit_vec;
    any_free = ~&row_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      clock_r    <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state_r != ST_OUT) out_valid <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SET_W'(DEPTH - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (rd_en) begin
            set_r   <= q_set;
            tag_r   <= q_tag;
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          priority if (any_hit) begin
            hit_r   <= 1'b1;
            way_r   <= hit_way;
            state_r <= ST_WRITE;
          end else if (any_free) begin
            hit_r   <= 1'b0;
            way_r   <= free_way;
            state_r <= ST_WRITE;
          end else begin
            hit_r   <= 1'b0;
            way_r   <= '0;
            best_r  <= row_stamp_r[0];
            scan_r  <= WIDX_W'(1);
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // one stamp per cycle, strict less keeps the lowest way on ties
          if (row_stamp_r[scan_r] < best_r) begin
            best_r <= row_stamp_r[scan_r];
            way_r  <= scan_r;
          end
          scan_r <= scan_r + 1'b1;
          if (scan_r == WIDX_W'(WAYS - 1)) state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          clock_r <= clock_r + 1'b1;
          if (hit_r) hit_cnt_r  <= hit_cnt_r + 1'b1;
          else       miss_cnt_r <= miss_cnt_r + 1'b1;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            out_hit        <= hit_r;
            out_way_used   <= WAY_W'(way_r);
            out_hit_total  <= hit_cnt_r;
            out_miss_total <= miss_cnt_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=>
      (CNT_W'(hit_cnt_r + miss_cnt_r) == CNT_W'($past(hit_cnt_r + miss_cnt_r) + 1'b1)))
    else $error("totals did not advance by one");
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> &row_valid_r)
    else $error("victim scan on a set with a free way");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !rd_en)
    else $error("item popped during clear");
`endif
endmodule
`default_nettype wire

[rtl/set_assoc_lru_cache_model.sv]
// top level of the set-associative lru cache tag model
//
//   channel | ports                              | handshake
//   in      | in_address                         | in_valid / in_stall
//   out     | out_hit, out_way_used, out_*_total | out_valid / out_stall
//   cfg     | cfg_set_index_bits                 | cfg_valid / cfg_ready
//
// an item goes from lookup straight to the tag write on a hit or a miss with a free way;
// when every way is valid the back end first scans one stamp per cycle for the victim.
// after reset the store's valid rows are cleared, one set a cycle, for all
// 2**floor(log2(MAX_SETS)) sets; in_stall stays high meanwhile.
// a two-entry queue lets the front take items while the back end works or stalls.
`default_nettype none
module set_assoc_lru_cache_model #(
  parameter int WAYS       = 16,
  parameter int LINE_BYTES = 64,
  parameter int MAX_SETS   = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [salc_pkg::ADDR_W-1:0] in_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic [salc_pkg::WAY_W-1:0]       out_way_used,
  output logic [salc_pkg::CNT_W-1:0]       out_hit_total,
  output logic [salc_pkg::CNT_W-1:0]       out_miss_total,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [salc_pkg::CFG_W-1:0]  cfg_set_index_bits
);
  import salc_pkg::*;

  localparam int MAX_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W    = (MAX_BITS > 0) ? MAX_BITS : 1;
  localparam int TAG_W    = ADDR_W - $clog2(LINE_BYTES);

  logic             clearing, q_valid, q_ready;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;

  salc_front #(.LINE_BYTES(LINE_BYTES), .MAX_SETS(MAX_SETS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_address,
    .cfg_valid, .cfg_ready, .cfg_set_index_bits,
    .clearing, .q_valid, .q_ready, .q_set, .q_tag
  );

  salc_back #(.WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .MAX_SETS(MAX_SETS)) u_back (
    .clk, .rst_n, .clearing, .q_valid, .q_ready, .q_set, .q_tag,
    .out_valid, .out_stall, .out_hit, .out_way_used, .out_hit_total, .out_miss_total
  );
endmodule
`default_nettype wire
